### rtl/core/aod_pkg.sv
// ----------------------------------------------------------------------------
// Audio onset detector package
// Shared widths, register map, multiplier operand codes and the command and
// status bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package aod_pkg;

    // Default sizes of the sample and the smoothing coefficient.
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int COEF_BITS_DEFAULT   = 16;

    // Fixed widths of energies, counter, side mode and the reported level.
    localparam int ENERGY_W   = 31;
    localparam int ENERGY_FRAC = 30;
    localparam int COUNT_W    = 24;
    localparam int MODE_W     = 2;
    localparam int LEVEL_W    = 16;
    localparam int ROOT_W     = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Register reset values.
    localparam int unsigned DECAY_RESET      = 65534;
    localparam int unsigned FLOOR_RESET      = 107374;
    localparam int unsigned REFRACTORY_RESET = 2400;
    localparam int unsigned SIDE_MODE_RESET  = 0;

    // Register indexes (word address).
    localparam logic [1:0] REG_DECAY      = 2'd0;
    localparam logic [1:0] REG_FLOOR      = 2'd1;
    localparam logic [1:0] REG_REFRACTORY = 2'd2;
    localparam logic [1:0] REG_SIDE_MODE  = 2'd3;

    // Side modes.
    localparam logic [MODE_W-1:0] SIDE_ALTERNATE = 2'd0;
    localparam logic [MODE_W-1:0] SIDE_LEFT      = 2'd1;

    // Operand selections of the shared multiplier.
    localparam logic [2:0] MUL_SQUARE   = 3'd0;
    localparam logic [2:0] MUL_C_ENV    = 3'd1;
    localparam logic [2:0] MUL_IC_ENVIN = 3'd2;
    localparam logic [2:0] MUL_C_TRK    = 3'd3;
    localparam logic [2:0] MUL_IC_E     = 3'd4;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic       capture;
        logic       count_inc;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       load_e;
        logic       acc_load;
        logic       env_write;
        logic       trk_write;
        logic       decide;
        logic       sqrt_step;
        logic       out_load;
    } cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic onset;
        logic sqrt_last;
        logic out_busy;
    } status_t;

endpackage

### rtl/core/audio_onset_detector.sv
// ----------------------------------------------------------------------------
// Audio onset detector
// Energy envelope onset detector with APB configuration and valid/ready
// sample and result channels.
// ----------------------------------------------------------------------------
// Each accepted sample that causes no onset passes through the accept
// cycle and seven sequencer steps, five of which pass through the single
// shared multiplier (square, then the two weighted products of each filter).
// A sample that causes an onset also passes through the square root, which
// resolves one result bit per cycle, and the load of the result word, which
// waits for the output register to be emptied. The output register holds a
// finished word while the next sample is processed.
// No clearing pass follows reset; registers read back at their reset values.
module audio_onset_detector #(
    parameter int SAMPLE_BITS = aod_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COEF_BITS   = aod_pkg::COEF_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aod_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [aod_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [aod_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_side_tag,
    output logic [aod_pkg::LEVEL_W-1:0]     m_onset_level
);
    import aod_pkg::*;

    logic [COEF_BITS-1:0] decay_coef;
    logic [ENERGY_W-1:0]  floor_energy;
    logic [COUNT_W-1:0]   refractory_samples;
    logic [MODE_W-1:0]    side_mode;
    cmd_t                 cmd;
    status_t              status;

    // Configuration registers.
    aod_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .decay_coef         (decay_coef),
        .floor_energy       (floor_energy),
        .refractory_samples (refractory_samples),
        .side_mode          (side_mode)
    );

    // Sequencer.
    aod_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath.
    aod_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_sample           (s_sample),
        .decay_coef         (decay_coef),
        .floor_energy       (floor_energy),
        .refractory_samples (refractory_samples),
        .side_mode          (side_mode),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_side_tag         (m_side_tag),
        .m_onset_level      (m_onset_level)
    );

endmodule

### rtl/core/aod_regs.sv
// ----------------------------------------------------------------------------
// Audio onset detector register file
// APB-style configuration registers with read back; pready is tied high.
// ----------------------------------------------------------------------------
module aod_regs #(
    parameter int COEF_BITS = aod_pkg::COEF_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [aod_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [aod_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [aod_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [COEF_BITS-1:0]               decay_coef,
    output logic [aod_pkg::ENERGY_W-1:0]       floor_energy,
    output logic [aod_pkg::COUNT_W-1:0]        refractory_samples,
    output logic [aod_pkg::MODE_W-1:0]         side_mode
);
    import aod_pkg::*;

    logic [COEF_BITS-1:0] decay_reg;
    logic [ENERGY_W-1:0]  floor_reg;
    logic [COUNT_W-1:0]   refr_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes on the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= COEF_BITS'(DECAY_RESET);
            floor_reg <= ENERGY_W'(FLOOR_RESET);
            refr_reg  <= COUNT_W'(REFRACTORY_RESET);
            mode_reg  <= MODE_W'(SIDE_MODE_RESET);
        end else if (wr_en) begin
            case (reg_idx)
                REG_DECAY:      decay_reg <= pwdata[COEF_BITS-1:0];
                REG_FLOOR:      floor_reg <= pwdata[ENERGY_W-1:0];
                REG_REFRACTORY: refr_reg  <= pwdata[COUNT_W-1:0];
                REG_SIDE_MODE:  mode_reg  <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (reg_idx)
            REG_DECAY:      prdata = APB_DATA_W'(decay_reg);
            REG_FLOOR:      prdata = APB_DATA_W'(floor_reg);
            REG_REFRACTORY: prdata = APB_DATA_W'(refr_reg);
            REG_SIDE_MODE:  prdata = APB_DATA_W'(mode_reg);
            default:        prdata = '0;
        endcase
    end

    assign decay_coef         = decay_reg;
    assign floor_energy       = floor_reg;
    assign refractory_samples = refr_reg;
    assign side_mode          = mode_reg;

endmodule

### rtl/core/aod_ctrl.sv
// ----------------------------------------------------------------------------
// Audio onset detector sequencer
// Steps each sample through the shared multiplier, the onset decision and,
// on an onset, the square root and the hand-over to the output register.
// ----------------------------------------------------------------------------
module aod_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  aod_pkg::status_t status,
    output aod_pkg::cmd_t    cmd
);
    import aod_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ     = 4'd1;
    localparam logic [3:0] ST_ENV0   = 4'd2;
    localparam logic [3:0] ST_ENV1   = 4'd3;
    localparam logic [3:0] ST_TRK0   = 4'd4;
    localparam logic [3:0] ST_TRK1   = 4'd5;
    localparam logic [3:0] ST_TRKW   = 4'd6;
    localparam logic [3:0] ST_DECIDE = 4'd7;
    localparam logic [3:0] ST_SQRT   = 4'd8;
    localparam logic [3:0] ST_LOAD   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_SQUARE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.count_inc = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_SQUARE;
                state_next    = ST_ENV0;
            end
            ST_ENV0: begin
                cmd.load_e  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C_ENV;
                state_next  = ST_ENV1;
            end
            ST_ENV1: begin
                cmd.acc_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_IC_ENVIN;
                state_next   = ST_TRK0;
            end
            ST_TRK0: begin
                cmd.env_write = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_C_TRK;
                state_next    = ST_TRK1;
            end
            ST_TRK1: begin
                cmd.acc_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_IC_E;
                state_next   = ST_TRKW;
            end
            ST_TRKW: begin
                cmd.trk_write = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.onset ? ST_SQRT : ST_IDLE;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The square root is only entered from an onset decision.
    a_sqrt_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |->
            ($past(state_reg) == ST_SQRT || $past(state_reg) == ST_DECIDE))
        else $error("square root entered without an onset decision");

    // A word is only handed to the output after a square root.
    a_load_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |->
            ($past(state_reg) == ST_LOAD || $past(state_reg) == ST_SQRT))
        else $error("output load reached without a square root");

endmodule

### rtl/core/aod_datapath.sv
// ----------------------------------------------------------------------------
// Audio onset detector datapath
// Shared multiplier, envelope and tracker filters, onset logic, bit-pair
// square root and the output register.
// ----------------------------------------------------------------------------
module aod_datapath #(
    parameter int SAMPLE_BITS = aod_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COEF_BITS   = aod_pkg::COEF_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  aod_pkg::cmd_t                      cmd,
    output aod_pkg::status_t                   status,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    input  logic [COEF_BITS-1:0]               decay_coef,
    input  logic [aod_pkg::ENERGY_W-1:0]       floor_energy,
    input  logic [aod_pkg::COUNT_W-1:0]        refractory_samples,
    input  logic [aod_pkg::MODE_W-1:0]         side_mode,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_side_tag,
    output logic [aod_pkg::LEVEL_W-1:0]        m_onset_level
);
    import aod_pkg::*;

    localparam int MB      = (SAMPLE_BITS > COEF_BITS + 1) ? SAMPLE_BITS : COEF_BITS + 1;
    localparam int PW      = ENERGY_W + MB;
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int SQ_FRAC = 2 * (SAMPLE_BITS - 1);
    localparam int SHR     = (SQ_FRAC >= ENERGY_FRAC) ? SQ_FRAC - ENERGY_FRAC : 0;
    localparam int SHL     = (SQ_FRAC < ENERGY_FRAC) ? ENERGY_FRAC - SQ_FRAC : 0;
    localparam int SQX_W   = SQ_W + SHL;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [ENERGY_W-1:0]           mul_a;
    logic [MB-1:0]                 mul_b;
    logic [MB-1:0]                 coef_b;
    logic [MB-1:0]                 icoef_b;
    logic [PW-1:0]                 prod_reg;
    logic [PW-1:0]                 acc_reg;
    logic [PW:0]                   smooth_sum;
    logic [ENERGY_W-1:0]           smooth_out;
    logic [SQX_W-1:0]              sq_x;
    logic [SQX_W-1:0]              sq_s;
    logic [ENERGY_W-1:0]           e_from_sq;
    logic [ENERGY_W-1:0]           e_reg;
    logic [ENERGY_W-1:0]           env_in;
    logic [ENERGY_W-1:0]           env_reg;
    logic [ENERGY_W-1:0]           trk_reg;
    logic                          last_above_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic [COUNT_W-1:0]            count_next;
    logic                          alt_reg;
    logic                          alt_next;
    logic                          tag_reg;
    logic                          tag_next;
    logic                          above;
    logic                          onset;
    logic [ROOT_W-1:0]             v_reg;
    logic [ROOT_W-1:0]             root_reg;
    logic [ENERGY_W-1:0]           bit_reg;
    logic [ROOT_W-1:0]             trial;
    logic                          m_valid_reg;
    logic                          m_side_tag_reg;
    logic [LEVEL_W-1:0]            m_onset_level_reg;

    // Sample magnitude; the most negative code maps to 2^(SAMPLE_BITS-1).
    assign mag = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;

    // Multiplier operands.
    assign coef_b  = MB'(decay_coef);
    assign icoef_b = MB'({1'b1, {COEF_BITS{1'b0}}}) - coef_b;
    assign env_in  = (e_reg > floor_energy) ? e_reg : floor_energy;

    always_comb begin
        case (cmd.mul_sel)
            MUL_SQUARE: begin
                mul_a = ENERGY_W'(mag);
                mul_b = MB'(mag);
            end
            MUL_C_ENV: begin
                mul_a = env_reg;
                mul_b = coef_b;
            end
            MUL_IC_ENVIN: begin
                mul_a = env_in;
                mul_b = icoef_b;
            end
            MUL_C_TRK: begin
                mul_a = trk_reg;
                mul_b = coef_b;
            end
            MUL_IC_E: begin
                mul_a = e_reg;
                mul_b = icoef_b;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Energy in Q1.30 from the registered square.
    assign sq_x      = SQX_W'(prod_reg[SQ_W-1:0]);
    assign sq_s      = sq_x << SHL;
    assign e_from_sq = ENERGY_W'(sq_s >> SHR);

    // One-pole filter output from the two weighted products.
    assign smooth_sum = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign smooth_out = ENERGY_W'(smooth_sum >> COEF_BITS);

    // Onset decision and side tag.
    assign above = (trk_reg > env_reg);
    assign onset = above && !last_above_reg && (count_reg > refractory_samples);

    always_comb begin
        count_next = count_reg;
        alt_next   = alt_reg;
        tag_next   = tag_reg;
        if (cmd.count_inc && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.decide && onset) begin
            count_next = '0;
            if (side_mode == SIDE_ALTERNATE) begin
                tag_next = ~alt_reg;
                alt_next = ~alt_reg;
            end else if (side_mode == SIDE_LEFT) begin
                tag_next = 1'b0;
            end else begin
                tag_next = 1'b1;
            end
        end
    end

    // Filter state, counter and flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg        <= '0;
            trk_reg        <= '0;
            last_above_reg <= 1'b0;
            count_reg      <= '0;
            alt_reg        <= 1'b0;
        end else begin
            count_reg <= count_next;
            alt_reg   <= alt_next;
            if (cmd.env_write) begin
                env_reg <= smooth_out;
            end
            if (cmd.trk_write) begin
                trk_reg <= (e_reg > trk_reg) ? e_reg : smooth_out;
            end
            if (cmd.decide) begin
                last_above_reg <= above;
            end
        end
    end

    // Payload registers of the arithmetic path.
    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
        if (cmd.capture) begin
            sample_reg <= s_sample;
        end
        if (cmd.mul_en) begin
            prod_reg <= PW'(mul_a * mul_b);
        end
        if (cmd.load_e) begin
            e_reg <= e_from_sq;
        end
        if (cmd.acc_load) begin
            acc_reg <= prod_reg;
        end
    end

    // Square root, one bit pair per cycle.
    assign trial = root_reg + ROOT_W'(bit_reg);

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            v_reg    <= ROOT_W'(trk_reg);
            root_reg <= '0;
            bit_reg  <= {1'b1, {(ENERGY_W-1){1'b0}}};
        end else if (cmd.sqrt_step) begin
            if (v_reg >= trial) begin
                v_reg    <= v_reg - trial;
                root_reg <= (root_reg >> 1) + ROOT_W'(bit_reg);
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_side_tag_reg    <= tag_reg;
            m_onset_level_reg <= root_reg[LEVEL_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_side_tag    = m_side_tag_reg;
    assign m_onset_level = m_onset_level_reg;

    assign status.onset     = onset;
    assign status.sqrt_last = bit_reg[0];
    assign status.out_busy  = m_valid_reg && !m_ready;

    // A new word never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && m_valid_reg) |-> m_ready)
        else $error("output word overwritten before it was taken");

    // An onset restarts the sample counter.
    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.decide && onset) |=> (count_reg == '0))
        else $error("sample counter not restarted on onset");

    // The root of a 31-bit energy stays within range.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_onset_level_reg <= LEVEL_W'(46340)))
        else $error("onset level out of range");

endmodule

### dv/audio_onset_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio onset detector testbench
// Drives samples and configuration writes into the detector and checks every
// reported onset against a cycle-free model of the energy envelope, the fast
// tracker, the refractory counter and the side tag, or against a typed-in word.
// A directed table comes first, then random phases of quiet/loud bursts and
// noise under several register settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module audio_onset_detector_tb;

    // Cycles allowed for a sample still being worked on once the last result
    // has arrived.
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int PHASE_ITEMS   = 232;

    // Side modes and tags not named in the package.
    localparam logic [aod_pkg::MODE_W-1:0] SIDE_RIGHT = 2'd2;
    localparam logic [aod_pkg::MODE_W-1:0] SIDE_SPARE = 2'd3;
    localparam logic TAG_LEFT  = 1'b0;
    localparam logic TAG_RIGHT = 1'b1;

    typedef struct packed {
        logic                         side;
        logic [aod_pkg::LEVEL_W-1:0]  level;
    } onset_word_t;

    // Directed table rows: a register write, a sample checked by the model,
    // a sample that must give no word, or a sample with a typed-in word.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PREDICT,
        ROW_QUIET,
        ROW_ONSET
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         reg_idx;
        logic [31:0]        value;
        logic signed [15:0] smp;
        onset_word_t        word;
    } dir_row_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [aod_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [aod_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [aod_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;
    logic        s_valid  = 1'b0;
    logic        s_ready;
    logic signed [15:0] s_sample = '0;
    logic        m_valid;
    logic        m_ready  = 1'b0;
    logic        m_side_tag;
    logic [aod_pkg::LEVEL_W-1:0] m_onset_level;

    // Model copy of the registers and the detector state.
    logic [15:0] cfg_decay;
    logic [30:0] cfg_floor;
    logic [23:0] cfg_refractory;
    logic [1:0]  cfg_side_mode;
    logic [30:0] envelope_q;
    logic [30:0] tracker_q;
    logic        was_above_q;
    logic [23:0] since_onset_q;
    logic        alt_flag_q;

    onset_word_t expected_onsets[$];
    onset_word_t head_word;
    dir_row_t    dir_rows[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          mismatch_seen = 1'b0;

    audio_onset_detector u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_side_tag    (m_side_tag),
        .m_onset_level (m_onset_level)
    );

    always #1 aclk = ~aclk;

    // One-pole smoothing step in Q0.16, truncated to 31 bits.
    function automatic logic [30:0] one_pole(input logic [30:0] prev, input logic [30:0] x);
        logic [63:0] acc;
        acc = 64'(cfg_decay) * 64'(prev) + (64'd65536 - 64'(cfg_decay)) * 64'(x);
        return acc[46:16];
    endfunction

    // Integer square root, one result bit at a time from the top.
    function automatic logic [15:0] energy_root(input logic [30:0] v);
        logic [15:0] root;
        logic [15:0] cand;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            cand = root | (16'd1 << b);
            if (32'(cand) * 32'(cand) <= 32'(v))
                root = cand;
        end
        return root;
    endfunction

    // Advances the detector state by one sample; returns 1 on an onset.
    function automatic bit step_detector(input logic signed [15:0] smp,
                                         output onset_word_t word);
        logic [16:0] mag;
        logic [33:0] sq;
        logic [30:0] e;
        logic [30:0] env_in;
        logic        above;
        bit          fire;
        mag = smp[15] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
        sq  = 34'(mag) * 34'(mag);
        e   = sq[30:0];
        if (since_onset_q != 24'hFFFFFF)
            since_onset_q = since_onset_q + 24'd1;
        env_in     = (e > cfg_floor) ? e : cfg_floor;
        envelope_q = one_pole(envelope_q, env_in);
        tracker_q  = (e > tracker_q) ? e : one_pole(tracker_q, e);
        above = tracker_q > envelope_q;
        fire  = above && !was_above_q && (since_onset_q > cfg_refractory);
        was_above_q = above;
        word = '0;
        if (fire) begin
            case (cfg_side_mode)
                aod_pkg::SIDE_ALTERNATE: begin
                    word.side  = alt_flag_q ? TAG_LEFT : TAG_RIGHT;
                    alt_flag_q = ~alt_flag_q;
                end
                aod_pkg::SIDE_LEFT: word.side = TAG_LEFT;
                default: word.side = TAG_RIGHT;
            endcase
            word.level    = energy_root(tracker_q);
            since_onset_q = '0;
        end
        return fire;
    endfunction

    // Presents one sample and returns at the edge where it is taken.
    task automatic send_sample(input logic signed [15:0] smp);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Sends a sample and queues whatever word the model expects from it.
    task automatic feed(input logic signed [15:0] smp);
        onset_word_t word;
        send_sample(smp);
        if (step_detector(smp, word)) begin
            expected_onsets.push_back(word);
        end
    endtask

    // Waits until every expected word has come and the block has gone idle.
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_onsets.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write with a setup and an access phase; the model copy follows it.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            aod_pkg::REG_DECAY:      cfg_decay      = value[15:0];
            aod_pkg::REG_FLOOR:      cfg_floor      = value[30:0];
            aod_pkg::REG_REFRACTORY: cfg_refractory = value[23:0];
            default:                 cfg_side_mode  = value[1:0];
        endcase
    endtask

    task automatic add_write(input logic [1:0] idx, input logic [31:0] value);
        dir_row_t r;
        r = '{ROW_WRITE, idx, value, 16'sd0, '0};
        dir_rows.push_back(r);
    endtask

    task automatic add_sample(input row_kind_t kind, input logic signed [15:0] smp,
                              input logic side, input logic [15:0] level);
        dir_row_t r;
        r = '{kind, 2'd0, 32'd0, smp, '{side, level}};
        dir_rows.push_back(r);
    endtask

    // A quiet run followed by a short loud run, the shape that leads to onsets.
    task automatic send_burst(inout int count);
        int quiet_len;
        int quiet_amp;
        int loud_len;
        int amp;
        quiet_len = $urandom_range(24, 2);
        quiet_amp = $urandom_range(1500, 0);
        loud_len  = $urandom_range(6, 1);
        repeat (quiet_len) begin
            amp = $urandom_range(quiet_amp, 0);
            feed($urandom_range(1) ? 16'(-amp) : 16'(amp));
            count++;
        end
        repeat (loud_len) begin
            amp = $urandom_range(32767, 4096);
            if ($urandom_range(7) == 0)
                feed(-16'sd32768);
            else
                feed($urandom_range(1) ? 16'(-amp) : 16'(amp));
            count++;
        end
    endtask

    // Result channel back-pressure, redrawn every cycle.
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Each word taken is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_onsets.size() == 0) begin
                $display("%0t: unexpected word side_tag %0d onset_level %0d",
                         $time, m_side_tag, m_onset_level);
                mismatch_seen = 1'b1;
            end else begin
                head_word = expected_onsets.pop_front();
                if (m_side_tag !== head_word.side) begin
                    $display("%0t: side_tag expected %0d, got %0d",
                             $time, head_word.side, m_side_tag);
                    mismatch_seen = 1'b1;
                end
                if (m_onset_level !== head_word.level) begin
                    $display("%0t: onset_level expected %0d, got %0d",
                             $time, head_word.level, m_onset_level);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("** audio_onset_detector: FAILED **");
        $finish;
    end

    // Main sequence.
    initial begin
        onset_word_t word;
        int          phase;
        int          items_in_phase;
        logic [15:0] decay;
        logic [30:0] floor_val;
        logic [23:0] refr;
        logic [1:0]  mode;

        cfg_decay      = 16'(aod_pkg::DECAY_RESET);
        cfg_floor      = 31'(aod_pkg::FLOOR_RESET);
        cfg_refractory = 24'(aod_pkg::REFRACTORY_RESET);
        cfg_side_mode  = 2'(aod_pkg::SIDE_MODE_RESET);
        envelope_q     = '0;
        tracker_q      = '0;
        was_above_q    = 1'b0;
        since_onset_q  = '0;
        alt_flag_q     = 1'b0;

        // Directed table. At reset the refractory count holds back the first
        // loud sample. A zero coefficient makes both filters follow the input,
        // so the tracker never stands above the envelope, and a zero sample then
        // clears both, which gives a known start for each typed-in onset.
        add_sample(ROW_QUIET, 16'sd0, TAG_LEFT, 16'd0);
        add_sample(ROW_QUIET, 16'sd32767, TAG_LEFT, 16'd0);
        add_write(aod_pkg::REG_DECAY, 32'd0);
        add_write(aod_pkg::REG_FLOOR, 32'd0);
        add_write(aod_pkg::REG_REFRACTORY, 32'd0);
        add_sample(ROW_QUIET, 16'sd12345, TAG_LEFT, 16'd0);
        add_sample(ROW_QUIET, 16'sd0, TAG_LEFT, 16'd0);
        // Alternating mode: the first onset is tagged right.
        add_write(aod_pkg::REG_DECAY, 32'h8000);
        add_sample(ROW_ONSET, 16'sd32767, TAG_RIGHT, 16'd32767);
        add_sample(ROW_PREDICT, -16'sd32768, TAG_LEFT, 16'd0);
        add_write(aod_pkg::REG_DECAY, 32'd0);
        add_sample(ROW_QUIET, 16'sd0, TAG_LEFT, 16'd0);
        // Fixed left, with the most negative sample giving the top level.
        add_write(aod_pkg::REG_DECAY, 32'h8000);
        add_write(aod_pkg::REG_SIDE_MODE, 32'(aod_pkg::SIDE_LEFT));
        add_sample(ROW_ONSET, -16'sd32768, TAG_LEFT, 16'd32768);
        add_write(aod_pkg::REG_DECAY, 32'd0);
        add_sample(ROW_QUIET, 16'sd0, TAG_LEFT, 16'd0);
        add_write(aod_pkg::REG_DECAY, 32'h8000);
        add_write(aod_pkg::REG_SIDE_MODE, 32'(SIDE_RIGHT));
        add_sample(ROW_ONSET, -16'sd1, TAG_RIGHT, 16'd1);
        // The unused side mode tags right as well.
        add_write(aod_pkg::REG_DECAY, 32'd0);
        add_sample(ROW_QUIET, 16'sd0, TAG_LEFT, 16'd0);
        add_write(aod_pkg::REG_DECAY, 32'h8000);
        add_write(aod_pkg::REG_SIDE_MODE, 32'(SIDE_SPARE));
        add_sample(ROW_ONSET, 16'sd1, TAG_RIGHT, 16'd1);
        // Back to alternating: the flag was left set, so this one is left.
        add_write(aod_pkg::REG_SIDE_MODE, 32'(aod_pkg::SIDE_ALTERNATE));
        add_write(aod_pkg::REG_DECAY, 32'd0);
        add_sample(ROW_QUIET, 16'sd0, TAG_LEFT, 16'd0);
        add_write(aod_pkg::REG_DECAY, 32'h8000);
        add_sample(ROW_ONSET, 16'sd181, TAG_LEFT, 16'd181);
        // The largest refractory count blocks every onset.
        add_write(aod_pkg::REG_REFRACTORY, 32'hFF_FFFF);
        add_write(aod_pkg::REG_DECAY, 32'd0);
        add_sample(ROW_QUIET, 16'sd0, TAG_LEFT, 16'd0);
        add_write(aod_pkg::REG_DECAY, 32'h8000);
        add_sample(ROW_QUIET, 16'sd32767, TAG_LEFT, 16'd0);
        // A floor beyond the largest energy, and the slowest coefficient.
        add_write(aod_pkg::REG_FLOOR, 32'h7FFF_FFFF);
        add_write(aod_pkg::REG_REFRACTORY, 32'd0);
        add_write(aod_pkg::REG_DECAY, 32'hFFFF);
        add_sample(ROW_PREDICT, 16'sd32767, TAG_LEFT, 16'd0);
        add_sample(ROW_PREDICT, -16'sd32768, TAG_LEFT, 16'd0);
        add_sample(ROW_PREDICT, 16'sd0, TAG_LEFT, 16'd0);
        // The fastest non-zero coefficient.
        add_write(aod_pkg::REG_FLOOR, 32'h4000_0000);
        add_write(aod_pkg::REG_DECAY, 32'd1);
        add_sample(ROW_PREDICT, -16'sd32768, TAG_LEFT, 16'd0);
        add_sample(ROW_PREDICT, 16'sd21845, TAG_LEFT, 16'd0);
        add_sample(ROW_PREDICT, -16'sd21846, TAG_LEFT, 16'd0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                quiesce();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end else if (dir_rows[i].kind == ROW_PREDICT) begin
                feed(dir_rows[i].smp);
            end else begin
                send_sample(dir_rows[i].smp);
                void'(step_detector(dir_rows[i].smp, word));
                if (dir_rows[i].kind == ROW_ONSET)
                    expected_onsets.push_back(dir_rows[i].word);
            end
        end

        // Random phases: fixed extremes first, then random settings; each
        // phase also takes the next idling pattern in turn.
        phase = 0;
        while (phase * PHASE_ITEMS < RANDOM_ITEMS) begin
            quiesce();
            case (phase)
                0: begin
                    decay = 16'hE000; floor_val = 31'd1 << 20;
                    refr = 24'd4; mode = aod_pkg::SIDE_ALTERNATE;
                end
                1: begin
                    decay = 16'hFFFF; floor_val = '0;
                    refr = '0; mode = aod_pkg::SIDE_LEFT;
                end
                2: begin
                    decay = 16'h8000; floor_val = 31'h7FFF_FFFF;
                    refr = '0; mode = SIDE_RIGHT;
                end
                3: begin
                    decay = 16'd1; floor_val = 31'd1 << 24;
                    refr = 24'd2; mode = SIDE_SPARE;
                end
                default: begin
                    decay     = 16'($urandom_range(16'hF800, 16'h8000));
                    floor_val = 31'($urandom_range(1 << 25, 0));
                    refr      = 24'($urandom_range(24, 0));
                    mode      = 2'($urandom_range(3, 0));
                end
            endcase
            write_reg(aod_pkg::REG_DECAY, 32'(decay));
            write_reg(aod_pkg::REG_FLOOR, 32'(floor_val));
            write_reg(aod_pkg::REG_REFRACTORY, 32'(refr));
            write_reg(aod_pkg::REG_SIDE_MODE, 32'(mode));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            items_in_phase = 0;
            while (items_in_phase < PHASE_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    send_burst(items_in_phase);
                end else begin
                    feed(16'($urandom_range(16'hFFFF, 0)));
                    items_in_phase++;
                end
            end
            phase++;
        end

        quiesce();
        if (!mismatch_seen)
            $display("** audio_onset_detector: PASSED **");
        else
            $display("** audio_onset_detector: FAILED **");
        $finish;
    end

endmodule
